// ===== rtl/core/psg_pkg.sv =====
`default_nettype none
package psg_pkg;

    localparam logic [31:0] MUL_A  = 32'hD2511F53;
    localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
    localparam logic [31:0] WEYL_A = 32'h9E3779B9;
    localparam logic [31:0] WEYL_B = 32'hBB67AE85;

    // Item opcodes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    // Register index, taken from paddr[3].
    localparam logic REG_SEED   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    // Buffer position that marks an empty word buffer.
    localparam logic [2:0] POS_EMPTY = 3'd4;

    typedef struct packed {
        logic        op;
        logic [63:0] stream_number;
        logic [31:0] range_size;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage
`default_nettype wire

// ===== rtl/core/psg_front.sv =====
`default_nettype none
module psg_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic [63:0]         stream_number,
    input  wire logic [31:0]         range_size,
    output psg_pkg::queue_head_t     head,
    input  wire logic                pop
);

    psg_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop_ok;

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign pop_ok     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg].op            <= op;
            entry_reg[wr_ptr_reg].stream_number <= stream_number;
            entry_reg[wr_ptr_reg].range_size    <= range_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_ok) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop_ok);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("psg_front: queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("psg_front: pointers differ on an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg != 2'd0) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("psg_front: pop did not drain an entry");

endmodule
`default_nettype wire

// ===== rtl/core/psg_back.sv =====
`default_nettype none
module psg_back #(
    parameter int ROUNDS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire psg_pkg::queue_head_t head,
    output logic                      pop,
    input  wire logic [63:0]          key,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [31:0]               random_word,
    output logic [31:0]               scaled_index
);

    localparam int RW = $clog2(ROUNDS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_DRAW  = 3'b100
    } state_t;

    state_t         state_reg;
    logic [RW-1:0]  round_reg;
    logic [31:0]    x0_reg, x1_reg, x2_reg, x3_reg;
    logic [31:0]    k0_reg, k1_reg;
    logic [31:0]    buf_reg [4];
    logic [2:0]     pos_reg;
    logic [63:0]    count_reg;
    logic [63:0]    stream_reg;
    logic [31:0]    range_reg;
    logic           out_valid_reg;
    logic [31:0]    word_out_reg;
    logic [31:0]    index_out_reg;

    logic [63:0]    pa, pb;
    logic [31:0]    n0, n1, n2, n3;
    logic           last_round;
    logic           out_free;
    logic [31:0]    draw_word;
    logic [63:0]    draw_prod;

    // One Philox round per cycle on the registered counter words.
    assign pa = 64'(psg_pkg::MUL_A) * 64'(x0_reg);
    assign pb = 64'(psg_pkg::MUL_B) * 64'(x2_reg);
    assign n0 = pb[63:32] ^ x1_reg ^ k0_reg;
    assign n1 = pb[31:0];
    assign n2 = pa[63:32] ^ x3_reg ^ k1_reg;
    assign n3 = pa[31:0];

    assign last_round = (round_reg == RW'(ROUNDS - 1));
    assign out_free   = !out_valid_reg || !out_stall;
    assign draw_word  = buf_reg[pos_reg[1:0]];
    assign draw_prod  = 64'(draw_word) * 64'(range_reg);

    assign pop          = (state_reg == ST_IDLE) && head.valid;
    assign out_valid    = out_valid_reg;
    assign random_word  = word_out_reg;
    assign scaled_index = index_out_reg;

    always_ff @(posedge clk) begin
        case (state_reg)
            ST_IDLE: begin
                if (head.valid && head.item.op == psg_pkg::OP_DRAW) begin
                    range_reg <= head.item.range_size;
                    x0_reg    <= count_reg[31:0];
                    x1_reg    <= count_reg[63:32];
                    x2_reg    <= stream_reg[31:0];
                    x3_reg    <= stream_reg[63:32];
                    k0_reg    <= key[31:0];
                    k1_reg    <= key[63:32];
                end
            end
            ST_ROUND: begin
                x0_reg <= n0;
                x1_reg <= n1;
                x2_reg <= n2;
                x3_reg <= n3;
                k0_reg <= k0_reg + psg_pkg::WEYL_A;
                k1_reg <= k1_reg + psg_pkg::WEYL_B;
                if (last_round) begin
                    buf_reg[0] <= n0;
                    buf_reg[1] <= n1;
                    buf_reg[2] <= n2;
                    buf_reg[3] <= n3;
                end
            end
            ST_DRAW: begin
                if (out_free) begin
                    word_out_reg  <= draw_word;
                    index_out_reg <= draw_prod[63:32];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            pos_reg       <= psg_pkg::POS_EMPTY;
            count_reg     <= '0;
            stream_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (state_reg == ST_DRAW && out_free) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (head.valid) begin
                        if (head.item.op == psg_pkg::OP_START) begin
                            stream_reg <= head.item.stream_number;
                            count_reg  <= '0;
                            pos_reg    <= psg_pkg::POS_EMPTY;
                        end
                        else if (pos_reg[2]) begin
                            round_reg <= '0;
                            state_reg <= ST_ROUND;
                        end
                        else begin
                            state_reg <= ST_DRAW;
                        end
                    end
                end
                ST_ROUND: begin
                    round_reg <= round_reg + RW'(1);
                    if (last_round) begin
                        pos_reg   <= 3'd0;
                        count_reg <= count_reg + 64'd1;
                        state_reg <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    if (out_free) begin
                        pos_reg   <= pos_reg + 3'd1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= psg_pkg::POS_EMPTY)
        else $error("psg_back: buffer position out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> !pos_reg[2])
        else $error("psg_back: draw from an empty buffer");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && last_round) |=> (state_reg == ST_DRAW && pos_reg == 3'd0))
        else $error("psg_back: refill did not reset the buffer position");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("psg_back: queue popped while busy");

endmodule
`default_nettype wire

// ===== rtl/core/philox_stream_generator_unit.sv =====
// Philox 4x32 stream generator.
// A draw takes the next word from the four-word buffer when it holds one;
// an empty buffer is first refilled by ROUNDS rounds, one per cycle, on the single
// round unit. Later requests wait; the front queue holds up to two of them.
// Reset clears seed, offset, stream, block count and queue, and marks the buffer empty.
`default_nettype none
module philox_stream_generator_unit #(
    parameter int ROUNDS = 10
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         op,
    input  wire logic [63:0]  stream_number,
    input  wire logic [31:0]  range_size,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [31:0]       random_word,
    output logic [31:0]       scaled_index
);

    logic [63:0]          seed_reg;
    logic [63:0]          offset_reg;
    logic                 wr_en;
    psg_pkg::queue_head_t head;
    logic                 pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == psg_pkg::REG_OFFSET) ? offset_reg : seed_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_reg   <= '0;
            offset_reg <= '0;
        end
        else if (wr_en) begin
            if (paddr[3] == psg_pkg::REG_SEED) begin
                seed_reg <= pwdata;
            end
            else begin
                offset_reg <= pwdata;
            end
        end
    end

    psg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .stream_number (stream_number),
        .range_size    (range_size),
        .head          (head),
        .pop           (pop)
    );

    psg_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .key          (seed_reg ^ offset_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_word  (random_word),
        .scaled_index (scaled_index)
    );

endmodule
`default_nettype wire

// ===== bench/tb_philox_stream_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_philox_stream_generator_unit;

    localparam int ROUNDS = 10;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = ROUNDS + 8;

    typedef struct {
        logic [31:0] word;
        logic [31:0] index;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = psg_pkg::OP_DRAW;
    logic [63:0] stream_number = '0;
    logic [31:0] range_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] random_word;
    logic [31:0] scaled_index;

    // Predictor state for the generator.
    logic [63:0] seed_reg = '0;
    logic [63:0] offset_reg = '0;
    logic [63:0] block_count = '0;
    logic [63:0] stream_id = '0;
    logic [31:0] word_store [4] = '{default: '0};
    logic [2:0]  word_pos = psg_pkg::POS_EMPTY;

    draw_result_t pending_draws [$];
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_output = 1'b0;
    int quiet_cycles = 0;

    philox_stream_generator_unit #(.ROUNDS(ROUNDS)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .stream_number(stream_number),
        .range_size(range_size),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .random_word(random_word),
        .scaled_index(scaled_index)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Ten Philox rounds on the current counter, keyed by seed XOR offset.
    function automatic void refill_words();
        logic [63:0] key;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [31:0] k0, k1, x0, x1, x2, x3;
        key = seed_reg ^ offset_reg;
        k0 = key[31:0];
        k1 = key[63:32];
        x0 = block_count[31:0];
        x1 = block_count[63:32];
        x2 = stream_id[31:0];
        x3 = stream_id[63:32];
        for (int r = 0; r < ROUNDS; r++)
        begin
            pa = {32'b0, psg_pkg::MUL_A} * {32'b0, x0};
            pb = {32'b0, psg_pkg::MUL_B} * {32'b0, x2};
            x0 = pb[63:32] ^ x1 ^ k0;
            x1 = pb[31:0];
            x2 = pa[63:32] ^ x3 ^ k1;
            x3 = pa[31:0];
            k0 = k0 + psg_pkg::WEYL_A;
            k1 = k1 + psg_pkg::WEYL_B;
        end
        word_store[0] = x0;
        word_store[1] = x1;
        word_store[2] = x2;
        word_store[3] = x3;
        word_pos = '0;
        block_count = block_count + 64'd1;
    endfunction

    function automatic void predict_request(input logic op_i, input logic [63:0] sn,
                                            input logic [31:0] rs);
        draw_result_t res;
        logic [63:0] prod;
        if (op_i == psg_pkg::OP_START)
        begin
            stream_id = sn;
            block_count = '0;
            word_pos = psg_pkg::POS_EMPTY;
        end
        else
        begin
            if (word_pos >= psg_pkg::POS_EMPTY)
                refill_words();
            res.word = word_store[word_pos[1:0]];
            word_pos = word_pos + 3'd1;
            prod = {32'b0, res.word} * {32'b0, rs};
            res.index = prod[63:32];
            pending_draws.push_back(res);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic op_i, input logic [63:0] sn, input logic [31:0] rs);
        while ($urandom_range(99) < tx_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        op = op_i;
        stream_number = sn;
        range_size = rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(op_i, sn, rs);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_register(input logic reg_sel, input logic [63:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_sel, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_sel == psg_pkg::REG_SEED)
            seed_reg = value;
        else
            offset_reg = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // A start request yields nothing, so allow the block time to finish it as well.
    task automatic wait_for_drain();
        while (pending_draws.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        hold_output = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_output = 1'b0;
    endtask

    function automatic logic [31:0] pick_range();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_stream();
        case ($urandom_range(7))
            0: return 64'h0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_draws_from_reset();
        send_request(psg_pkg::OP_DRAW, 64'h0, 32'h0);
        send_request(psg_pkg::OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(psg_pkg::OP_DRAW, 64'h0, 32'h1);
        send_request(psg_pkg::OP_DRAW, 64'h0, 32'h8000_0000);
        send_request(psg_pkg::OP_DRAW, 64'h0, 32'd6);
        send_request(psg_pkg::OP_DRAW, 64'h0, $urandom);
    endtask

    task automatic test_stream_extremes();
        wait_for_drain();
        write_register(psg_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(psg_pkg::REG_OFFSET, 64'h0);
        send_request(psg_pkg::OP_START, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
        repeat (5) send_request(psg_pkg::OP_DRAW, 64'($urandom), pick_range());
        send_request(psg_pkg::OP_START, 64'h0, 32'h0);
        send_request(psg_pkg::OP_START, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
        send_request(psg_pkg::OP_DRAW, 64'h0, 32'hFFFF_FFFF);
        send_request(psg_pkg::OP_START, 64'h0, 32'h0);
        send_request(psg_pkg::OP_DRAW, 64'h0, 32'h0);
    endtask

    // New key takes effect at the next refill, even inside a stream.
    task automatic test_key_change_mid_stream();
        send_request(psg_pkg::OP_DRAW, 64'h0, $urandom);
        wait_for_drain();
        write_register(psg_pkg::REG_OFFSET, 64'hA5A5_5A5A_0F0F_F0F0);
        repeat (5) send_request(psg_pkg::OP_DRAW, 64'h0, $urandom);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        wait_for_drain();
        write_register(psg_pkg::REG_SEED, {$urandom, $urandom});
        write_register(psg_pkg::REG_OFFSET, {$urandom, $urandom});
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count)
        begin
            if ($urandom_range(7) == 0)
                send_request(psg_pkg::OP_START, pick_stream(), $urandom);
            else
                send_request(psg_pkg::OP_DRAW, {$urandom, $urandom}, pick_range());
        end
    endtask

    task automatic test_output_backpressure();
        wait_for_drain();
        write_register(psg_pkg::REG_SEED, 64'h0);
        write_register(psg_pkg::REG_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(psg_pkg::OP_START, pick_stream(), 32'h0);
        fork
            hold_receiver(300);
            repeat (60) send_request(psg_pkg::OP_DRAW, {$urandom, $urandom}, pick_range());
        join
    endtask

    always @(negedge clk)
    begin
        if (hold_output)
            out_stall = 1'b1;
        else
            out_stall = ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual word %h index %h",
                         $time, random_word, scaled_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (random_word !== want.word)
                begin
                    $display("%0t: random_word mismatch: expected %h, actual %h",
                             $time, want.word, random_word);
                    mismatch_count++;
                end
                if (scaled_index !== want.index)
                begin
                    $display("%0t: scaled_index mismatch: expected %h, actual %h",
                             $time, want.index, scaled_index);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_draws_from_reset();
        test_stream_extremes();
        test_key_change_mid_stream();
        test_random_traffic(36, 68, 420);
        test_random_traffic(68, 36, 420);
        test_random_traffic(0, 0, 420);
        test_output_backpressure();

        while (pending_draws.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_draws.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, pending_draws.size());
        if (mismatch_count == 0 && pending_draws.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
